// ===== design/ifu_pkg.sv =====
package ifu_pkg;

   // Frame layout
   localparam int unsigned FRAME_LEN  = 18;
   localparam int unsigned STORED_LEN = FRAME_LEN - 1;
   localparam int unsigned POS_W      = 5;
   localparam int unsigned WORD_W     = 16;
   localparam int unsigned PREFIX_W   = 7;
   localparam int unsigned STAMP_W    = PREFIX_W + WORD_W;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(STORED_LEN);

   // Byte offsets of the time word within the frame
   localparam int unsigned TIME_LO = 12;
   localparam int unsigned TIME_HI = 13;

   // Control from the frame sequencer to the time tracker
   typedef struct packed {
      logic restart;
      logic commit;
   } ifu_ctl_type;

endpackage

// ===== design/imu_fifo_frame_unpacker.sv =====
// Deframes the sensor FIFO byte stream into records of six 16-bit samples and
// a 23-bit extended time. One byte is taken per cycle, back to back; the
// eighteenth byte of each frame loads the single output register, so that
// byte, or a restart offered in its place, waits only while a previous record
// sits unread there. A record shows on the result port the cycle after its
// last byte transfers. Bytes move through a shift line of seventeen byte
// cells; a restart transfer clears the frame position, the wrap prefix and
// the last time and stores nothing. No clearing pass follows reset.
module imu_fifo_frame_unpacker
   import ifu_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_fifo_byte,
   input  logic                       req_restart,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [WORD_W-1:0]   rsp_gyro_x,
   output logic signed [WORD_W-1:0]   rsp_gyro_y,
   output logic signed [WORD_W-1:0]   rsp_gyro_z,
   output logic signed [WORD_W-1:0]   rsp_accel_x,
   output logic signed [WORD_W-1:0]   rsp_accel_y,
   output logic signed [WORD_W-1:0]   rsp_accel_z,
   output logic [STAMP_W-1:0]         rsp_stamp
);

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             accept;
   logic             at_last;
   logic             shift;
   ifu_ctl_type      ctl;
   logic [7:0]       cell_q [STORED_LEN];
   logic [STAMP_W-1:0] stamp;

   logic [WORD_W-1:0] word   [6];
   logic [WORD_W-1:0] word_ff [6];
   logic [STAMP_W-1:0] stamp_ff;

   // The last byte of a frame needs the output register free or draining
   assign at_last   = (pos_ff >= LAST_POS);
   assign req_ready = !at_last || !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign shift       = accept && !req_restart && !at_last;
   assign ctl.restart = accept && req_restart;
   assign ctl.commit  = accept && !req_restart && at_last;

   // Shift line: cell 0 takes the new byte, each cell hands to the next
   for (genvar i = 0; i < STORED_LEN; i++) begin : g_cell
      if (i == 0) begin : g_head
         ifu_byte_cell u_cell (
            .clock (clock),
            .shift (shift),
            .d_in  (req_fifo_byte),
            .q     (cell_q[i])
         );
      end else begin : g_body
         ifu_byte_cell u_cell (
            .clock (clock),
            .shift (shift),
            .d_in  (cell_q[i-1]),
            .q     (cell_q[i])
         );
      end
   end

   // Frame byte j sits in cell STORED_LEN-1-j when the last byte arrives
   for (genvar k = 0; k < 6; k++) begin : g_word
      assign word[k] = {cell_q[STORED_LEN-2-2*k], cell_q[STORED_LEN-1-2*k]};
   end

   ifu_stamp_track u_stamp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .time_word ({cell_q[STORED_LEN-1-TIME_HI], cell_q[STORED_LEN-1-TIME_LO]}),
      .stamp     (stamp)
   );

   // Advance the frame position
   always_comb begin
      pos_in = pos_ff;
      if (ctl.restart || ctl.commit) begin
         pos_in = '0;
      end else if (shift) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   // Output register: load on commit, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         word_ff  <= word;
         stamp_ff <= stamp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gyro_x  = word_ff[0];
   assign rsp_gyro_y  = word_ff[1];
   assign rsp_gyro_z  = word_ff[2];
   assign rsp_accel_x = word_ff[3];
   assign rsp_accel_y = word_ff[4];
   assign rsp_accel_z = word_ff[5];
   assign rsp_stamp   = stamp_ff;

endmodule

// ===== design/ifu_byte_cell.sv =====
module ifu_byte_cell
   import ifu_pkg::*;
(
   input  logic       clock,
   input  logic       shift,
   input  logic [7:0] d_in,
   output logic [7:0] q
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // Take the neighbor's byte on a shift, hold otherwise
   always_comb begin
      byte_in = shift ? d_in : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign q = byte_ff;

endmodule

// ===== design/ifu_stamp_track.sv =====
module ifu_stamp_track
   import ifu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ifu_ctl_type         ctl,
   input  logic [WORD_W-1:0]   time_word,
   output logic [STAMP_W-1:0]  stamp
);

   logic [WORD_W-1:0]   prev_time_ff;
   logic [WORD_W-1:0]   prev_time_in;
   logic [PREFIX_W-1:0] prefix_ff;
   logic [PREFIX_W-1:0] prefix_in;
   logic [PREFIX_W-1:0] prefix_next;

   // Count a wrap when the time steps backward; the prefix wraps at 7 bits
   always_comb begin
      prefix_next = (time_word < prev_time_ff) ? prefix_ff + PREFIX_W'(1) : prefix_ff;
      prefix_in    = prefix_ff;
      prev_time_in = prev_time_ff;
      if (ctl.restart) begin
         prefix_in    = '0;
         prev_time_in = '0;
      end else if (ctl.commit) begin
         prefix_in    = prefix_next;
         prev_time_in = time_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff    <= '0;
         prev_time_ff <= '0;
      end else begin
         prefix_ff    <= prefix_in;
         prev_time_ff <= prev_time_in;
      end
   end

   assign stamp = {prefix_next, time_word};

endmodule

// ===== design/ifu_checker.sv =====
module ifu_checker
   import ifu_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_restart,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [STAMP_W-1:0]        rsp_stamp
);

   // A stalled record holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stamp))
      else $error("stalled record changed");

   // Nothing is shown right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("record after reset");

   // A new record follows only a data byte transfer
   a_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && !req_restart))
      else $error("record without a byte");

   // A restart transfer never yields a record
   a_restart: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_restart && !(rsp_valid && !rsp_ready) |=> !rsp_valid)
      else $error("record after restart");

endmodule

bind imu_fifo_frame_unpacker ifu_checker u_ifu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_restart (req_restart),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_stamp   (rsp_stamp)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import ifu_pkg::*;

   // One deframed record, laid out like the result port
   typedef struct packed {
      logic signed [WORD_W-1:0] gyro_x;
      logic signed [WORD_W-1:0] gyro_y;
      logic signed [WORD_W-1:0] gyro_z;
      logic signed [WORD_W-1:0] accel_x;
      logic signed [WORD_W-1:0] accel_y;
      logic signed [WORD_W-1:0] accel_z;
      logic [STAMP_W-1:0]       stamp;
   } imu_rec_type;

   // One row of the directed byte table
   typedef struct {
      logic [7:0]  fbyte;
      logic        restart;
      bit          fixed;
      imu_rec_type rec;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [7:0]                req_fifo_byte;
   logic                      req_restart;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [WORD_W-1:0]  rsp_gyro_x;
   logic signed [WORD_W-1:0]  rsp_gyro_y;
   logic signed [WORD_W-1:0]  rsp_gyro_z;
   logic signed [WORD_W-1:0]  rsp_accel_x;
   logic signed [WORD_W-1:0]  rsp_accel_y;
   logic signed [WORD_W-1:0]  rsp_accel_z;
   logic [STAMP_W-1:0]        rsp_stamp;

   // Deframer state mirrored by the testbench
   logic [POS_W-1:0]    frame_pos;
   logic [7:0]          frame_mem [STORED_LEN];
   logic [WORD_W-1:0]   tracked_time;
   logic [PREFIX_W-1:0] wrap_count;

   imu_rec_type  expected_records [$];
   stim_row_type directed_rows [$];
   int           error_count     = 0;
   int           records_checked = 0;
   int           bytes_sent      = 0;
   int           restarts_sent   = 0;
   bit           rollover_seen   = 1'b0;
   bit           send_calm       = 1'b0;
   bit           sink_calm       = 1'b0;

   imu_fifo_frame_unpacker uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_fifo_byte (req_fifo_byte),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_gyro_x    (rsp_gyro_x),
      .rsp_gyro_y    (rsp_gyro_y),
      .rsp_gyro_z    (rsp_gyro_z),
      .rsp_accel_x   (rsp_accel_x),
      .rsp_accel_y   (rsp_accel_y),
      .rsp_accel_z   (rsp_accel_z),
      .rsp_stamp     (rsp_stamp)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Advance the deframer by one byte; return 1 when a record completes
   function automatic bit deframe_step(input logic [7:0] b, input logic r,
                                       output imu_rec_type rec);
      logic [WORD_W-1:0] t;
      rec = '0;
      if (r) begin
         frame_pos    = '0;
         wrap_count   = '0;
         tracked_time = '0;
         return 1'b0;
      end
      if (frame_pos < LAST_POS) begin
         frame_mem[frame_pos] = b;
         frame_pos = frame_pos + POS_W'(1);
         return 1'b0;
      end
      // final byte of the frame is consumed but never stored
      frame_pos   = '0;
      rec.gyro_x  = {frame_mem[1], frame_mem[0]};
      rec.gyro_y  = {frame_mem[3], frame_mem[2]};
      rec.gyro_z  = {frame_mem[5], frame_mem[4]};
      rec.accel_x = {frame_mem[7], frame_mem[6]};
      rec.accel_y = {frame_mem[9], frame_mem[8]};
      rec.accel_z = {frame_mem[11], frame_mem[10]};
      t = {frame_mem[TIME_HI], frame_mem[TIME_LO]};
      // a strictly earlier time counts one wrap; the prefix rolls over at 128
      if (t < tracked_time) begin
         if (&wrap_count) rollover_seen = 1'b1;
         wrap_count = wrap_count + PREFIX_W'(1);
      end
      tracked_time = t;
      rec.stamp = {wrap_count, t};
      return 1'b1;
   endfunction

   // Mostly short gaps, a few long ones, none while calm
   function automatic int pick_gap(input bit calm);
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Sample bytes lean toward sign and range boundaries
   function automatic logic [7:0] sample_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h7F;
         3: return 8'h80;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one byte, hold it until the transfer, then predict
   task automatic send_item(input logic [7:0] b, input logic r, input bit fixed,
                            input imu_rec_type frec);
      int          gap;
      imu_rec_type rec;
      if ($urandom_range(0, 149) == 0) send_calm = ~send_calm;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_fifo_byte <= b;
      req_restart   <= r;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (r) restarts_sent++;
      if (deframe_step(b, r, rec)) expected_records.push_back(fixed ? frec : rec);
   endtask

   // Send one frame carrying time t; a cut in 0..17 aborts it with a restart
   task automatic send_frame(input logic [WORD_W-1:0] t, input int cut);
      logic [7:0] b;
      for (int i = 0; i < FRAME_LEN; i++) begin
         if (i == cut) begin
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
            return;
         end
         if (i < TIME_LO) b = sample_byte();
         else if (i == TIME_LO) b = t[7:0];
         else if (i == TIME_HI) b = t[15:8];
         else b = 8'($urandom_range(0, 255));
         send_item(b, 1'b0, 1'b0, '0);
      end
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Result side: random stalls with calm stretches
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      rsp_ready <= 1'b1;
      forever begin
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if ($urandom_range(0, 29) == 0) sink_calm = ~sink_calm;
         stall = pick_gap(sink_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each transferred record with the oldest expectation
   always @(posedge clock) begin
      imu_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_records.size() == 0) begin
            error_count++;
            $display("%0t: unexpected record: expected none, got stamp %h",
                     $time, rsp_stamp);
         end else begin
            want = expected_records.pop_front();
            records_checked++;
            check_field("gyro_x", want.gyro_x, rsp_gyro_x);
            check_field("gyro_y", want.gyro_y, rsp_gyro_y);
            check_field("gyro_z", want.gyro_z, rsp_gyro_z);
            check_field("accel_x", want.accel_x, rsp_accel_x);
            check_field("accel_y", want.accel_y, rsp_accel_y);
            check_field("accel_z", want.accel_z, rsp_accel_z);
            check_field("stamp", want.stamp, rsp_stamp);
         end
      end
   end

   // Stimulus
   initial begin
      logic [7:0]        ext_frame [FRAME_LEN];
      imu_rec_type       ext_rec;
      logic [WORD_W-1:0] t;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_fifo_byte <= '0;
      req_restart   <= 1'b0;
      frame_pos    = '0;
      tracked_time = '0;
      wrap_count   = '0;
      foreach (frame_mem[i]) frame_mem[i] = '0;

      // Extreme samples and the largest time, straight after reset
      ext_frame = '{8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF,
                    8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
                    8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h5A, 8'hA5};
      ext_rec = '{gyro_x: 16'sh7FFF, gyro_y: 16'sh8000, gyro_z: 16'shFFFF,
                  accel_x: 16'sh0000, accel_y: 16'sh00FF, accel_z: 16'shFF00,
                  stamp: 23'h00FFFF};
      for (int i = 0; i < FRAME_LEN; i++)
         directed_rows.push_back('{ext_frame[i], 1'b0, i == FRAME_LEN - 1, ext_rec});
      // restart with a full-scale byte that must be dropped
      directed_rows.push_back('{8'hFF, 1'b1, 1'b0, '0});
      // partial frame cut off by a restart
      directed_rows.push_back('{8'h12, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h34, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h56, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h78, 1'b0, 1'b0, '0});
      directed_rows.push_back('{8'h00, 1'b1, 1'b0, '0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].fbyte, directed_rows[i].restart,
                   directed_rows[i].fixed, directed_rows[i].rec);

      // Restart-free run of mostly falling times to count the prefix up
      for (int f = 0; f < 60; f++) begin
         if (f > 0 && $urandom_range(0, 49) == 0) t = tracked_time;
         else if (tracked_time > 64) t = tracked_time - 16'($urandom_range(1, 64));
         else t = 16'hFFFF - 16'($urandom_range(0, 255));
         send_frame(t, -1);
      end

      // Hold the sender until every record has drained
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);

      // Mixed frames, aborted frames and stray restarts
      for (int f = 0; f < 12; f++) begin
         case ($urandom_range(0, 9))
            0: t = 16'h0000;
            1: t = 16'hFFFF;
            2, 3: t = tracked_time;
            default: t = 16'($urandom_range(0, 65535));
         endcase
         if ($urandom_range(0, 9) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
         if ($urandom_range(0, 6) == 0) send_frame(t, $urandom_range(0, 17));
         else send_frame(t, -1);
      end

      // Drain and settle
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d bytes (%0d restarts) and %0d checked records;",
               bytes_sent, restarts_sent, records_checked);
      $display("wrap prefix rollover %s.", rollover_seen ? "exercised" : "not reached");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("Timeout with %0d records outstanding", expected_records.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
